### rtl/wbps_pkg.sv
package wbps_pkg;

  localparam int PATTERN_MAX_DEF = 64;
  localparam int MAX_MATCHES_DEF = 256;
  localparam int BYTE_W          = 8;
  localparam int ENTRY_W         = BYTE_W + 1;  // {care, byte}
  localparam int OFFSET_W        = 32;
  localparam int STATUS_W        = 2;

  // input item kinds (tuser)
  localparam logic CMD_PATTERN = 1'b0;
  localparam logic CMD_DATA    = 1'b1;

  // result item kinds (tuser)
  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // summary status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_PAT    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 2'd3;

  typedef struct packed {
    logic win_shift;  // advance the data window by one byte
    logic pat_shift;  // advance the pattern chain by one entry
  } cell_ctl_t;

endpackage

### rtl/wildcard_byte_pattern_search.sv
// Wildcard byte pattern search. Send a pattern first (tuser = 0), one byte per
// item with its must-match flag, tlast on the final pattern byte; then send the
// data stream (tuser = 1), tlast on the final data byte. Every complete window
// whose start offset is at least start_offset and whose must-match bytes agree
// yields a match item carrying that start offset and the running count; the
// final data byte also yields a summary item with the count and a status (ok,
// too many matches, no pattern, pattern too long). Matches past MAX_MATCHES are
// dropped and flagged in the summary. A pattern byte arriving after a finished
// load starts a new pattern and clears the search. One item is taken per clock
// while the output stage has room: each item shifts one row of PATTERN_MAX cells,
// which compare every pattern position against the window in that same cycle.
// Results leave via a two-slot output stage; a data item that gives both a match
// and a summary holds in_tready low while the summary waits to drain. Write
// start_offset only while the block is idle.
module wildcard_byte_pattern_search #(
  parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF,
  parameter int MAX_MATCHES = wbps_pkg::MAX_MATCHES_DEF,
  parameter int CNT_W       = $clog2(MAX_MATCHES + 1),
  parameter int OUT_W       = ((wbps_pkg::OFFSET_W + CNT_W + wbps_pkg::STATUS_W + 1 + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_wr_en,
  input  logic [wbps_pkg::OFFSET_W-1:0]   cfg_wr_data,   // start_offset
  // input items
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,      // byte_value[7:0], care[8]
  input  logic                            in_tuser,      // cmd
  input  logic                            in_tlast,      // last
  // result items
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [OUT_W-1:0]                out_tdata,     // match_offset, match_count,
                                                         // status, final_res
  output logic                            out_tuser      // kind
);

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int POS_W = wbps_pkg::OFFSET_W;

  // configuration register
  logic [POS_W-1:0] start_offset_r;

  // search state
  logic [LEN_W-1:0] len_r, len_nxt, len_base;
  logic             too_long_r, too_long_nxt;
  logic             loading_r, loading_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] count_r, count_nxt, count_after;
  logic             ovf_r, ovf_nxt;

  // output stage: one visible slot plus one waiting summary
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;
  logic             out_kind_r, out_kind_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  logic [OUT_W-1:0] pend_data_r, pend_data_nxt;

  logic                        accept, is_pat, is_data, new_pat, pat_room;
  logic                        stream_clear, out_free;
  logic                        window_full, in_range, hit, cnt_room, emit_match, emit_sum;
  logic                        mismatch_any;
  logic [POS_W:0]              pos_plus;
  logic [POS_W-1:0]            win_start;
  logic [wbps_pkg::STATUS_W-1:0] sum_status;
  logic [OUT_W-1:0]            match_word, sum_word;
  wbps_pkg::cell_ctl_t         cell_ctl;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = out_free && !pend_valid_r;
  assign accept    = in_tvalid && in_tready;
  assign is_pat    = in_tuser == wbps_pkg::CMD_PATTERN;
  assign is_data   = in_tuser == wbps_pkg::CMD_DATA;

  // a pattern byte outside a load opens a new pattern from length zero
  assign new_pat  = is_pat && !loading_r;
  assign len_base = new_pat ? '0 : len_r;
  assign pat_room = len_base < LEN_W'(PATTERN_MAX);

  assign cell_ctl.win_shift = accept && is_data;
  assign cell_ctl.pat_shift = accept && is_pat && pat_room;

  wbps_chain #(
    .PATTERN_MAX(PATTERN_MAX),
    .LEN_W      (LEN_W)
  ) u_chain (
    .clk         (clk),
    .ctl         (cell_ctl),
    .len         (len_r),
    .data_byte   (in_tdata[wbps_pkg::BYTE_W-1:0]),
    .pat_entry   (in_tdata[wbps_pkg::ENTRY_W-1:0]),
    .mismatch_any(mismatch_any)
  );

  // window start offset of the window completed by this data byte
  assign pos_plus    = {1'b0, pos_r} + (POS_W+1)'(1);
  assign window_full = pos_plus >= (POS_W+1)'(len_r);
  assign win_start   = POS_W'(pos_plus - (POS_W+1)'(len_r));
  assign in_range    = win_start >= start_offset_r;

  assign hit = accept && is_data && (len_r != '0) && !too_long_r &&
               window_full && in_range && !mismatch_any;
  assign cnt_room    = count_r < CNT_W'(MAX_MATCHES);
  assign emit_match  = hit && cnt_room;
  assign count_after = emit_match ? count_r + CNT_W'(1) : count_r;
  assign emit_sum    = accept && is_data && in_tlast;

  assign stream_clear = accept && (new_pat || (is_data && in_tlast));

  // summary status priority: no pattern, too long, overflow, ok
  always_comb begin
    if (len_r == '0) begin
      sum_status = wbps_pkg::ST_NO_PAT;
    end else if (too_long_r) begin
      sum_status = wbps_pkg::ST_TOO_LONG;
    end else if (ovf_r || (hit && !cnt_room)) begin
      sum_status = wbps_pkg::ST_OVERFLOW;
    end else begin
      sum_status = wbps_pkg::ST_OK;
    end
  end

  assign match_word = OUT_W'({1'b0, wbps_pkg::ST_OK, count_after, win_start});
  assign sum_word   = OUT_W'({1'b1, sum_status, count_after, POS_W'(0)});

  // search state update
  always_comb begin
    len_nxt      = len_r;
    too_long_nxt = too_long_r;
    loading_nxt  = loading_r;
    pos_nxt      = pos_r;
    count_nxt    = count_r;
    ovf_nxt      = ovf_r;
    if (accept && is_pat) begin
      len_nxt      = pat_room ? len_base + LEN_W'(1) : len_base;
      too_long_nxt = (new_pat ? 1'b0 : too_long_r) || !pat_room;
      loading_nxt  = !in_tlast;
    end
    if (accept && is_data) begin
      loading_nxt = 1'b0;
      // saturate at the top of the offset range
      pos_nxt     = pos_plus[POS_W] ? pos_r : pos_plus[POS_W-1:0];
      count_nxt   = count_after;
      if (hit && !cnt_room) begin
        ovf_nxt = 1'b1;
      end
    end
    if (stream_clear) begin
      pos_nxt   = '0;
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end
  end

  // output stage: drain the waiting summary first, then load new results
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_kind_nxt   = out_kind_r;
    pend_valid_nxt = pend_valid_r;
    pend_data_nxt  = pend_data_r;
    if (out_free) begin
      out_valid_nxt = 1'b0;
      if (pend_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = pend_data_r;
        out_kind_nxt   = wbps_pkg::KIND_SUMMARY;
        pend_valid_nxt = 1'b0;
      end else if (emit_match) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = match_word;
        out_kind_nxt   = wbps_pkg::KIND_MATCH;
        pend_valid_nxt = emit_sum;
        pend_data_nxt  = sum_word;
      end else if (emit_sum) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = sum_word;
        out_kind_nxt  = wbps_pkg::KIND_SUMMARY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_offset_r <= '0;
      len_r          <= '0;
      too_long_r     <= 1'b0;
      loading_r      <= 1'b0;
      pos_r          <= '0;
      count_r        <= '0;
      ovf_r          <= 1'b0;
      out_valid_r    <= 1'b0;
      pend_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        start_offset_r <= cfg_wr_data;
      end
      len_r        <= len_nxt;
      too_long_r   <= too_long_nxt;
      loading_r    <= loading_nxt;
      pos_r        <= pos_nxt;
      count_r      <= count_nxt;
      ovf_r        <= ovf_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    out_kind_r  <= out_kind_nxt;
    pend_data_r <= pend_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

endmodule

### rtl/wbps_cell.sv
module wbps_cell #(
  parameter int IDX   = 0,
  parameter int LEN_W = 7
) (
  input  logic                         clk,
  input  wbps_pkg::cell_ctl_t          ctl,
  input  logic [LEN_W-1:0]             len,
  input  logic [wbps_pkg::BYTE_W-1:0]  win_in,
  input  logic [wbps_pkg::ENTRY_W-1:0] pat_in,
  output logic [wbps_pkg::BYTE_W-1:0]  win_out,
  output logic [wbps_pkg::ENTRY_W-1:0] pat_out,
  output logic                         mismatch
);

  logic [wbps_pkg::BYTE_W-1:0]  win_r;
  logic [wbps_pkg::ENTRY_W-1:0] pat_r;
  logic                         active;

  always_ff @(posedge clk) begin
    if (ctl.win_shift) begin
      win_r <= win_in;
    end
    if (ctl.pat_shift) begin
      pat_r <= pat_in;
    end
  end

  // compare against the byte that lands here on this shift
  assign active   = LEN_W'(IDX) < len;
  assign mismatch = active && pat_r[wbps_pkg::BYTE_W] &&
                    (pat_r[wbps_pkg::BYTE_W-1:0] != win_in);
  assign win_out  = win_r;
  assign pat_out  = pat_r;

endmodule

### rtl/wbps_chain.sv
module wbps_chain #(
  parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF,
  parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
  input  logic                         clk,
  input  wbps_pkg::cell_ctl_t          ctl,
  input  logic [LEN_W-1:0]             len,
  input  logic [wbps_pkg::BYTE_W-1:0]  data_byte,
  input  logic [wbps_pkg::ENTRY_W-1:0] pat_entry,
  output logic                         mismatch_any
);

  logic [wbps_pkg::BYTE_W-1:0]  win_link [PATTERN_MAX+1];
  logic [wbps_pkg::ENTRY_W-1:0] pat_link [PATTERN_MAX+1];
  logic [PATTERN_MAX-1:0]       mis;

  assign win_link[0] = data_byte;
  assign pat_link[0] = pat_entry;

  // cell k holds pattern entry len-1-k and compares it with window byte len-1-k
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    wbps_cell #(
      .IDX  (k),
      .LEN_W(LEN_W)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .len     (len),
      .win_in  (win_link[k]),
      .pat_in  (pat_link[k]),
      .win_out (win_link[k+1]),
      .pat_out (pat_link[k+1]),
      .mismatch(mis[k])
    );
  end

  assign mismatch_any = |mis;

endmodule
